@@ hdl/sgmd_pkg.sv @@
`timescale 1ns / 1ps
package sgmd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int CFG_W      = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int MAG_W      = 15;
  localparam int DIR_W      = 15;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

  localparam int ANG_FRAC   = 60;
  localparam int VEC_SHIFT  = 50;
  localparam int ROT_STEPS  = 60;
  localparam int STEP_W     = $clog2(ROT_STEPS);
  localparam int SQRT_STEPS = 16;

  typedef logic signed [63:0] angle_t;
  typedef angle_t angle_tab_t [ROT_STEPS];

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     frame_end;
  } item_t;

  typedef struct packed {
    logic                     nonempty;
    logic [LEVEL_W-1:0]       level;
  } fifo_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_ROTATE,
    BK_FINISH
  } back_state_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem = rem - den;
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic angle_t atan_inverse(input logic [63:0] m);
    logic [63:0] p;
    logic [63:0] term;
    logic [63:0] mm;
    logic [63:0] n;
    angle_t      sum;
    p   = udiv64(64'd1 << ANG_FRAC, m);
    mm  = m * m;
    sum = '0;
    n   = '0;
    while (p != 0) begin
      term = udiv64(p, 2 * n + 1);
      if (n[0]) sum = sum - angle_t'(term);
      else sum = sum + angle_t'(term);
      p = udiv64(p, mm);
      n = n + 1;
    end
    return sum;
  endfunction

  function automatic angle_tab_t build_table();
    angle_tab_t  t;
    angle_t      sum;
    logic [63:0] term;
    int          e;
    t[0] = 4 * atan_inverse(64'd5) - atan_inverse(64'd239);
    for (int i = 1; i < ROT_STEPS; i++) begin
      sum = '0;
      for (int n = 0; n < 64; n++) begin
        e = ANG_FRAC - i * (2 * n + 1);
        if (e >= 0) begin
          term = udiv64(64'd1 << e, 64'(2 * n + 1));
          if (n % 2 == 1) sum = sum - angle_t'(term);
          else sum = sum + angle_t'(term);
        end
      end
      t[i] = sum;
    end
    return t;
  endfunction

  localparam angle_tab_t ROT_ANGLE  = build_table();
  localparam angle_t     PI_FIXED   = 4 * ROT_ANGLE[0];
  localparam angle_t     HALF_PI    = 2 * ROT_ANGLE[0];
  localparam angle_t     ROUND_BIAS = angle_t'(64'd1 << (ANG_FRAC - 13));

endpackage

@@ hdl/sgmd_front.sv @@
`timescale 1ns / 1ps
module sgmd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sgmd_pkg::PIX_W-1:0]  pixel,
  input  logic                        frame_start,
  input  logic [sgmd_pkg::CFG_W-1:0]  frame_width,
  input  logic [sgmd_pkg::CFG_W-1:0]  frame_height,
  input  sgmd_pkg::fifo_status_t      fifo_status,
  output logic                        push,
  output sgmd_pkg::item_t             push_item
);
  import sgmd_pkg::*;

  logic [COL_W-1:0] col, col_cur, col_next;
  logic [ROW_W-1:0] row, row_cur, row_next;
  logic [CFG_W-1:0] w_use, h_use, col_inc, row_inc;
  logic             emit_a, last_a, accept;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data, wr_data;
  logic               b_valid, b_emit, b_last;
  logic [PIX_W-1:0]   b_pix;
  logic [COL_W-1:0]   b_addr;
  logic [PIX_W-1:0]   win [6];
  logic [PIX_W-1:0]   rt, rm;
  logic signed [GRAD_W-1:0] left_sum, right_sum, top_sum, bottom_sum;

  always_comb begin
    if (frame_width < CFG_W'(3)) w_use = CFG_W'(3);
    else if (frame_width > CFG_W'(MAX_WIDTH)) w_use = CFG_W'(MAX_WIDTH);
    else w_use = frame_width;
    if (frame_height < CFG_W'(3)) h_use = CFG_W'(3);
    else if (frame_height > CFG_W'(MAX_HEIGHT)) h_use = CFG_W'(MAX_HEIGHT);
    else h_use = frame_height;
  end

  always_comb begin
    col_cur = frame_start ? '0 : col;
    row_cur = frame_start ? '0 : row;
    emit_a  = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2)) &&
              (CFG_W'(row_cur) < h_use) && (CFG_W'(col_cur) < w_use);
    last_a  = (CFG_W'(row_cur) == h_use - CFG_W'(1)) &&
              (CFG_W'(col_cur) == w_use - CFG_W'(1));
    col_inc = CFG_W'(col_cur) + CFG_W'(1);
    row_inc = CFG_W'(row_cur) + CFG_W'(1);
    if (col_inc >= w_use) begin
      col_next = '0;
      row_next = (row_inc >= h_use) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row_cur;
    end
  end

  assign in_stall = (CFG_W'(fifo_status.level) + CFG_W'(b_valid && b_emit)) >=
                    CFG_W'(FIFO_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  assign rt      = rd_data[2*PIX_W-1:PIX_W];
  assign rm      = rd_data[PIX_W-1:0];
  assign wr_data = {rm, b_pix};

  // The line store entry written by the pixel in flight is forwarded on a same-address read.
  always_ff @(posedge clk) begin
    if (b_valid) line_mem[b_addr] <= wr_data;
    if (accept) begin
      if (b_valid && (b_addr == col_cur)) rd_data <= wr_data;
      else rd_data <= line_mem[col_cur];
      b_pix  <= pixel;
      b_emit <= emit_a;
      b_last <= last_a;
      b_addr <= col_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) win[k] <= '0;
    end else if (b_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= rt;
      win[4] <= rm;
      win[5] <= b_pix;
    end
  end

  always_comb begin
    left_sum   = GRAD_W'(win[0]) + (GRAD_W'(win[1]) << 1) + GRAD_W'(win[2]);
    right_sum  = GRAD_W'(rt) + (GRAD_W'(rm) << 1) + GRAD_W'(b_pix);
    top_sum    = GRAD_W'(win[0]) + (GRAD_W'(win[3]) << 1) + GRAD_W'(rt);
    bottom_sum = GRAD_W'(win[2]) + (GRAD_W'(win[5]) << 1) + GRAD_W'(b_pix);
    push_item.grad_x    = left_sum - right_sum;
    push_item.grad_y    = top_sum - bottom_sum;
    push_item.frame_end = b_last;
    push = b_valid && b_emit;
  end

endmodule

@@ hdl/sgmd_fifo.sv @@
`timescale 1ns / 1ps
module sgmd_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sgmd_pkg::item_t        push_item,
  input  logic                   pop,
  output sgmd_pkg::item_t        pop_item,
  output sgmd_pkg::fifo_status_t status
);
  import sgmd_pkg::*;

  item_t              slots [FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [LEVEL_W-1:0] level;

  assign pop_item        = slots[rptr];
  assign status.level    = level;
  assign status.nonempty = (level != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) wptr <= wptr + PTR_W'(1);
      if (pop) rptr <= rptr + PTR_W'(1);
      level <= level + LEVEL_W'(push) - LEVEL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_item;
  end

endmodule

@@ hdl/sgmd_back.sv @@
`timescale 1ns / 1ps
module sgmd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  sgmd_pkg::fifo_status_t            fifo_status,
  input  sgmd_pkg::item_t                   pop_item,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sgmd_pkg::GRAD_W-1:0] grad_x,
  output logic signed [sgmd_pkg::GRAD_W-1:0] grad_y,
  output logic [sgmd_pkg::MAG_W-1:0]        magnitude,
  output logic signed [sgmd_pkg::DIR_W-1:0] direction,
  output logic                              frame_end
);
  import sgmd_pkg::*;

  back_state_t state, state_next;
  item_t       cur;
  logic [STEP_W-1:0] step;
  angle_t      x, y, z, xs, ys;
  logic [31:0] rad, root, bitv;
  logic [31:0] trial;
  logic [21:0] sq_x, sq_y;
  logic [GRAD_W-1:0] abs_x, abs_y;
  logic        load, out_free;
  angle_t      z_clamp, z_side, q_full;
  logic [DIR_W-1:0] q_dir;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (fifo_status.nonempty) state_next = BK_SQUARE;
      BK_SQUARE: state_next = BK_ROTATE;
      BK_ROTATE: if (step == STEP_W'(ROT_STEPS - 1)) state_next = BK_FINISH;
      BK_FINISH: if (out_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    case (state)
      BK_IDLE:   pop = fifo_status.nonempty;
      BK_FINISH: load = out_free;
      default: begin
        pop  = 1'b0;
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    abs_x = cur.grad_x[GRAD_W-1] ? GRAD_W'(-cur.grad_x) : cur.grad_x;
    abs_y = cur.grad_y[GRAD_W-1] ? GRAD_W'(-cur.grad_y) : cur.grad_y;
    sq_x  = 22'(abs_x) * 22'(abs_x);
    sq_y  = 22'(abs_y) * 22'(abs_y);
    xs    = x >>> step;
    ys    = y >>> step;
    trial = root + bitv;
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_item;
    case (state)
      BK_SQUARE: begin
        rad  <= 32'(sq_x + sq_y) << 8;
        root <= '0;
        bitv <= 32'd1 << 30;
        x    <= angle_t'(abs_x) <<< VEC_SHIFT;
        y    <= angle_t'(abs_y) <<< VEC_SHIFT;
        z    <= '0;
        step <= '0;
      end
      BK_ROTATE: begin
        step <= step + STEP_W'(1);
        if (!y[63] && (y != 0)) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ROT_ANGLE[step];
        end else if (y[63]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ROT_ANGLE[step];
        end
        if (step < STEP_W'(SQRT_STEPS)) begin
          if (rad >= trial) begin
            rad  <= rad - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (z[63]) z_clamp = '0;
    else if (z > HALF_PI) z_clamp = HALF_PI;
    else z_clamp = z;
    z_side = cur.grad_x[GRAD_W-1] ? PI_FIXED - z_clamp : z_clamp;
    q_full = (z_side + ROUND_BIAS) >>> (ANG_FRAC - 12);
    q_dir  = q_full[DIR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grad_x    <= cur.grad_x;
      grad_y    <= cur.grad_y;
      magnitude <= root[MAG_W-1:0];
      direction <= cur.grad_y[GRAD_W-1] ? DIR_W'(-q_dir) : q_dir;
      frame_end <= cur.frame_end;
    end
  end

endmodule

@@ hdl/sobel_gradient_mag_dir.sv @@
`timescale 1ns / 1ps
// Sobel edge detector over a raster stream of 8-bit grey pixels: for every interior pixel
// it returns the horizontal and vertical gradients, the magnitude in UQ11.4 and the
// direction in radians as Q2.12, and border pixels return nothing. The front end takes one
// pixel per clock while its four-entry result queue has room, but the back end works on one
// result at a time, running a 60-step shift-and-add rotation for the angle with a 16-step
// square root beside it, and pops the next result from the queue only once the
// last has been handed to the output. Set frame_width and frame_height only while
// the block is idle.
module sobel_gradient_mag_dir (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [sgmd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sgmd_pkg::PIX_W-1:0]         pixel,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sgmd_pkg::GRAD_W-1:0] grad_x,
  output logic signed [sgmd_pkg::GRAD_W-1:0] grad_y,
  output logic [sgmd_pkg::MAG_W-1:0]         magnitude,
  output logic signed [sgmd_pkg::DIR_W-1:0]  direction,
  output logic                               frame_end
);
  import sgmd_pkg::*;

  logic [CFG_W-1:0] frame_width, frame_height;
  fifo_status_t     fifo_status;
  item_t            push_item, pop_item;
  logic             push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
      if (cfg_index == REG_FRAME_HEIGHT) frame_height <= cfg_data;
    end
  end

  sgmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel        (pixel),
    .frame_start  (frame_start),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .fifo_status  (fifo_status),
    .push         (push),
    .push_item    (push_item)
  );

  sgmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (fifo_status)
  );

  sgmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_status (fifo_status),
    .pop_item    (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .magnitude   (magnitude),
    .direction   (direction),
    .frame_end   (frame_end)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (fifo_status.level == LEVEL_W'(FIFO_DEPTH))))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> fifo_status.nonempty)
    else $error("result queue underflow");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_status.level <= LEVEL_W'(FIFO_DEPTH))
    else $error("result queue level out of range");

endmodule

@@ sim/sobel_checker.sv @@
`timescale 1ns / 1ps
module sobel_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [sgmd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [sgmd_pkg::PIX_W-1:0]         pixel,
  input  logic                               frame_start,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [sgmd_pkg::GRAD_W-1:0] grad_x,
  input  logic signed [sgmd_pkg::GRAD_W-1:0] grad_y,
  input  logic [sgmd_pkg::MAG_W-1:0]         magnitude,
  input  logic signed [sgmd_pkg::DIR_W-1:0]  direction,
  input  logic                               frame_end,
  output int                                 mismatches,
  output int                                 pending
);
  import sgmd_pkg::*;

  typedef struct {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         mag;
    logic signed [DIR_W-1:0]  dir;
    logic                     fe;
  } edge_result_t;

  edge_result_t     edge_q[$];
  logic [PIX_W-1:0] row_above[MAX_WIDTH];
  logic [PIX_W-1:0] row_two_above[MAX_WIDTH];
  logic [PIX_W-1:0] win[6];
  int               col_pos;
  int               row_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  longint           turn_angle[60];
  longint           pi_q60;

  assign pending = edge_q.size();

  function automatic longint arctan_recip(longint unsigned m);
    longint unsigned p;
    longint unsigned n;
    longint          sum;
    p = (64'd1 << 60) / m;
    n = 0;
    sum = 0;
    while (p != 0) begin
      if (n[0]) sum = sum - longint'(p / (2 * n + 1));
      else sum = sum + longint'(p / (2 * n + 1));
      p = p / (m * m);
      n++;
    end
    return sum;
  endfunction

  function automatic int unsigned floor_sqrt(int unsigned v);
    longint unsigned r;
    r = longint'($sqrt(real'(v)));
    while ((r + 1) * (r + 1) <= v) r++;
    while (r * r > v) r--;
    return int'(r);
  endfunction

  function automatic int angle_q12(int dx, int dy);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint q;
    if (dx == 0 && dy == 0) return 0;
    x = longint'(dx < 0 ? -dx : dx) <<< 50;
    y = longint'(dy < 0 ? -dy : dy) <<< 50;
    z = 0;
    for (int i = 0; i < 60; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + turn_angle[i];
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z = z - turn_angle[i];
      end
    end
    if (z < 0) z = 0;
    if (z > pi_q60 / 2) z = pi_q60 / 2;
    if (dx < 0) z = pi_q60 - z;
    q = (z + (64'sd1 <<< 47)) >>> 48;
    return int'(dy < 0 ? -q : q);
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic take_pixel(logic [PIX_W-1:0] p, logic fs);
    int           w;
    int           h;
    int           c;
    int           r;
    int           lt, lm, lb, ct, cb, rt, rm, rb, dx, dy;
    edge_result_t e;
    w = int'(width_reg) < 3 ? 3 : (int'(width_reg) > MAX_WIDTH ? MAX_WIDTH : int'(width_reg));
    h = int'(height_reg) < 3 ? 3 :
        (int'(height_reg) > MAX_HEIGHT ? MAX_HEIGHT : int'(height_reg));
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos >= MAX_WIDTH ? 0 : col_pos;
    r = row_pos;
    rb = p;
    rt = row_two_above[c];
    rm = row_above[c];
    row_two_above[c] = rm;
    row_above[c] = p;
    lt = win[0]; lm = win[1]; lb = win[2]; ct = win[3]; cb = win[5];
    dx = (lt + 2 * lm + lb) - (rt + 2 * rm + rb);
    dy = (lt + 2 * ct + rt) - (lb + 2 * cb + rb);
    win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
    win[3] = rt; win[4] = rm; win[5] = p;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      e.gx = dx[GRAD_W-1:0];
      e.gy = dy[GRAD_W-1:0];
      e.mag = MAG_W'(floor_sqrt(int'(unsigned'(dx * dx + dy * dy)) * 256));
      e.dir = DIR_W'(angle_q12(dx, dy));
      e.fe = (r == h - 1 && c == w - 1);
      edge_q.push_back(e);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  initial begin
    turn_angle[0] = 4 * arctan_recip(5) - arctan_recip(239);
    pi_q60 = 4 * turn_angle[0];
    for (int i = 1; i < 60; i++) begin
      turn_angle[i] = 0;
      for (int n = 0; 60 - i * (2 * n + 1) >= 0; n++) begin
        if (n % 2 == 1)
          turn_angle[i] -= longint'((64'd1 << (60 - i * (2 * n + 1))) / (2 * n + 1));
        else
          turn_angle[i] += longint'((64'd1 << (60 - i * (2 * n + 1))) / (2 * n + 1));
      end
    end
  end

  // Everything is sampled mid-cycle, where the values for the coming edge are settled.
  always @(negedge clk) begin
    edge_result_t got;
    edge_result_t want;
    if (rst) begin
      mismatches = 0;
      edge_q.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i] = '0;
        row_two_above[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (in_valid && !in_stall) take_pixel(pixel, frame_start);
      if (out_valid && !out_stall) begin
        got.gx = grad_x; got.gy = grad_y; got.mag = magnitude;
        got.dir = direction; got.fe = frame_end;
        if (edge_q.size() == 0) begin
          report("result with none expected");
        end else begin
          want = edge_q.pop_front();
          if (got.gx !== want.gx)
            report($sformatf("grad_x %0d, expected %0d", got.gx, want.gx));
          if (got.gy !== want.gy)
            report($sformatf("grad_y %0d, expected %0d", got.gy, want.gy));
          if (got.mag !== want.mag)
            report($sformatf("magnitude %0d, expected %0d", got.mag, want.mag));
          if (got.dir !== want.dir)
            report($sformatf("direction %0d, expected %0d", got.dir, want.dir));
          if (got.fe !== want.fe)
            report($sformatf("frame_end %0b, expected %0b", got.fe, want.fe));
        end
      end
    end
  end
endmodule

@@ sim/tb_sobel_gradient_mag_dir.sv @@
`timescale 1ns / 1ps
module tb_sobel_gradient_mag_dir;
  import sgmd_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic                     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [PIX_W-1:0]         pixel;
  logic                     frame_start;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [MAG_W-1:0]         magnitude;
  logic signed [DIR_W-1:0]  direction;
  logic                     frame_end;
  int                       mismatches;
  int                       pending;
  logic                     calm;
  int                       pixels_sent;

  sobel_gradient_mag_dir uut (.*);

  sobel_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[sobel_gradient_mag_dir] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 29);
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] p, logic fs);
    logic took;
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= p;
    frame_start <= fs;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    pixels_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One frame of random pixels; it may be cut short, may skip its start mark and may pause halfway to drain.
  task automatic random_frame(int w, int h, bit mark, bit cut, bit hold);
    int n;
    int stop;
    n = w * h;
    stop = cut ? $urandom_range(n - 1, 1) : n;
    for (int i = 0; i < stop; i++) begin
      if (hold && i == n / 2) drain();
      send_pixel(8'($urandom), (i == 0) && mark);
    end
  endtask

  initial begin
    int w;
    int h;
    bit fresh;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = '0;
    frame_start = 1'b0;
    calm = 1'b0;
    pixels_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_frame(CFG_W'(3), CFG_W'(3));
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'hFF : 8'h00, i == 0);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2 || i >= 6) ? 8'hFF : 8'h00, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(8'h00, i == 0);
    set_frame(CFG_W'(2047), CFG_W'(2));
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom), i == 0);
    set_frame(CFG_W'(1), CFG_W'(1500));
    random_frame(3, 5, 1, 0, 0);
    set_frame(CFG_W'(0), CFG_W'(0));
    random_frame(3, 3, 1, 0, 0);
    random_frame(3, 3, 0, 0, 0);
    pixels_sent = 0;
    while (pixels_sent < 750) begin
      w = $urandom_range(9, 3);
      h = $urandom_range(7, 3);
      set_frame(CFG_W'(w), CFG_W'(h));
      calm = (pixels_sent == 0) || ($urandom_range(9) == 0);
      fresh = 1'b1;
      repeat ($urandom_range(4, 1)) begin
        random_frame(w, h, fresh || ($urandom_range(99) < 80),
                     $urandom_range(99) < 12, $urandom_range(99) < 5);
        fresh = 1'b0;
      end
      calm = 1'b0;
    end
    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("[sobel_gradient_mag_dir] OK");
    end else begin
      $display("[sobel_gradient_mag_dir] ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/sgmd_pkg.sv
hdl/sgmd_front.sv
hdl/sgmd_fifo.sv
hdl/sgmd_back.sv
hdl/sobel_gradient_mag_dir.sv
sim/sobel_checker.sv
sim/tb_sobel_gradient_mag_dir.sv
